### hw/rtl/utf8_display_width_scanner_defines.svh
// Assertion macros shared by the display width scanner checkers.
`ifndef UTF8_DISPLAY_WIDTH_SCANNER_DEFINES_SVH
`define UTF8_DISPLAY_WIDTH_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UDWS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("udws same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UDWS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("udws next-cycle check failed");

`endif

### hw/rtl/udws_pkg.sv
// Shared widths, byte class constants and the column width table of the scanner.
package udws_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int CW_W    = 2;
  localparam int INV_W   = 3;
  localparam int CNT_W   = 2;
  localparam int TOTAL_W = 16;

  // Byte classes of UTF-8.
  localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;
  localparam logic [BYTE_W-1:0] BITS_MASK    = 8'h3F;
  localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MIN    = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD3_MIN    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MIN    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_BAD_MIN = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD2_BITS   = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS   = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS   = 8'h07;

  typedef logic [CP_W-1:0] cp_t;
  typedef logic [CW_W-1:0] cw_t;

  // Terminal columns of a codepoint: zero for NUL, two for wide ranges, else one.
  function automatic cw_t col_width(input cp_t c);
    logic wide;
    wide = (c >= 21'h01100 && c <= 21'h0115F) ||
           (c == 21'h02329) || (c == 21'h0232A) ||
           (c >= 21'h02E80 && c <= 21'h0303E) ||
           (c >= 21'h03040 && c <= 21'h033FF) ||
           (c >= 21'h03400 && c <= 21'h04DBF) ||
           (c >= 21'h04E00 && c <= 21'h0A4CF) ||
           (c >= 21'h0A960 && c <= 21'h0A97F) ||
           (c >= 21'h0AC00 && c <= 21'h0D7FF) ||
           (c >= 21'h0F900 && c <= 21'h0FAFF) ||
           (c >= 21'h0FE10 && c <= 21'h0FE1F) ||
           (c >= 21'h0FE30 && c <= 21'h0FE6F) ||
           (c >= 21'h0FF00 && c <= 21'h0FF60) ||
           (c >= 21'h0FFE0 && c <= 21'h0FFE6) ||
           (c >= 21'h1B000 && c <= 21'h1B0FF) ||
           (c >= 21'h1F004 && c <= 21'h1F0CF) ||
           (c >= 21'h1F300 && c <= 21'h1F9FF) ||
           (c >= 21'h20000 && c <= 21'h2FFFD) ||
           (c >= 21'h30000 && c <= 21'h3FFFD);
    if (c == '0) begin
      return 2'd0;
    end else if (wide) begin
      return 2'd2;
    end
    return 2'd1;
  endfunction

endpackage

### hw/rtl/utf8_display_width_scanner.sv
// Streaming UTF-8 decoder that reports each codepoint with its terminal width.
//
// The scanner takes one text byte per transfer and returns exactly one result per
// byte. The byte is captured in an input register at its transfer, decoded against
// the pending-sequence state, and the result is captured in an output register
// once that register is free, and from there it drives the output ports. A new
// byte is accepted in every cycle in which in_stall is low; the decoder state
// (partial codepoint, byte counts and running width) is updated once per byte.
// The running width saturates at 2**WIDTH_BITS - 1, is reported through its
// low 16 bits, and clears after the byte marked as end of text. Invalid, aborted
// and unfinished bytes are counted in the result of the byte that discards them.
module utf8_display_width_scanner
  import udws_pkg::*;
#(
  parameter int WIDTH_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_data_in,
  input  logic               in_end_of_text,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_cp_done,
  output logic [CP_W-1:0]    out_codepoint,
  output logic [CW_W-1:0]    out_char_width,
  output logic [INV_W-1:0]   out_invalid_bytes,
  output logic [TOTAL_W-1:0] out_total_width,
  output logic               out_text_done
);

  localparam int SUM_W = WIDTH_BITS + 1;

  // Input register.
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;

  // Decoder state.
  logic [CP_W-1:0]       part_r, part_nxt;
  logic [CNT_W-1:0]      need_r, need_nxt;
  logic [CNT_W-1:0]      held_r, held_nxt;
  logic [WIDTH_BITS-1:0] run_r, run_nxt;

  // Output register.
  logic               out_valid_r;
  logic               out_cp_done_r, out_cp_done_nxt;
  logic [CP_W-1:0]    out_codepoint_r, out_codepoint_nxt;
  logic [CW_W-1:0]    out_char_width_r, out_char_width_nxt;
  logic [INV_W-1:0]   out_invalid_bytes_r, out_invalid_bytes_nxt;
  logic [TOTAL_W-1:0] out_total_width_r, out_total_width_nxt;
  logic               out_text_done_r;

  // Decode temporaries.
  logic                          pend;
  logic                          is_cont;
  logic [CP_W-1:0]               shifted;
  logic                          done;
  logic [CP_W-1:0]               cp;
  logic [INV_W-1:0]              inv;
  logic [CW_W-1:0]               cw;
  logic [SUM_W-1:0]              sum;
  logic [WIDTH_BITS-1:0]         run_sum;
  logic [WIDTH_BITS+TOTAL_W-1:0] tw_ext;

  // Handshake: the output register loads when empty or when its transfer completes.
  logic out_load;
  logic s1_adv;
  logic in_take;

  assign out_load = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_load;
  assign in_stall = s1_valid_r && !out_load;
  assign in_take  = in_valid && !in_stall;

  // Decode of the registered byte against the pending sequence.
  always_comb begin
    pend     = (need_r != '0);
    is_cont  = ((s1_byte_r & CONT_MASK) == CONT_TAG);
    shifted  = {part_r[CP_W-7:0], s1_byte_r[5:0] & BITS_MASK[5:0]};
    part_nxt = part_r;
    need_nxt = need_r;
    held_nxt = held_r;
    done     = 1'b0;
    cp       = '0;
    inv      = '0;

    // Continuation of the pending sequence, or its abort.
    if (pend) begin
      if (is_cont) begin
        need_nxt = need_r - 2'd1;
        if (need_r == 2'd1) begin
          done     = 1'b1;
          cp       = shifted;
          part_nxt = '0;
          held_nxt = '0;
        end else begin
          part_nxt = shifted;
          held_nxt = held_r + 2'd1;
        end
      end else begin
        inv      = INV_W'(held_r);
        need_nxt = '0;
        held_nxt = '0;
        part_nxt = '0;
      end
    end

    // Fresh decode as a lead byte.
    if (!(pend && is_cont)) begin
      if (s1_byte_r < ASCII_LIMIT) begin
        done = 1'b1;
        cp   = CP_W'(s1_byte_r);
      end else if (s1_byte_r < LEAD2_MIN) begin
        inv = inv + 3'd1;
      end else if (s1_byte_r < LEAD3_MIN) begin
        part_nxt = CP_W'(s1_byte_r & LEAD2_BITS);
        need_nxt = 2'd1;
        held_nxt = 2'd1;
      end else if (s1_byte_r < LEAD4_MIN) begin
        part_nxt = CP_W'(s1_byte_r & LEAD3_BITS);
        need_nxt = 2'd2;
        held_nxt = 2'd1;
      end else if (s1_byte_r < LEAD_BAD_MIN) begin
        part_nxt = CP_W'(s1_byte_r & LEAD4_BITS);
        need_nxt = 2'd3;
        held_nxt = 2'd1;
      end else begin
        inv = inv + 3'd1;
      end
    end

    // A sequence still open at the end of the text is discarded.
    if (s1_last_r && need_nxt != '0) begin
      inv      = inv + INV_W'(held_nxt);
      need_nxt = '0;
      held_nxt = '0;
      part_nxt = '0;
    end

    // Width and saturating running total.
    cw      = done ? col_width(cp) : '0;
    sum     = {1'b0, run_r} + SUM_W'(cw);
    run_sum = sum[WIDTH_BITS] ? '1 : sum[WIDTH_BITS-1:0];
    run_nxt = s1_last_r ? '0 : run_sum;
    tw_ext  = {{TOTAL_W{1'b0}}, run_sum};

    out_cp_done_nxt       = done;
    out_codepoint_nxt     = cp;
    out_char_width_nxt    = cw;
    out_invalid_bytes_nxt = inv;
    out_total_width_nxt   = tw_ext[TOTAL_W-1:0];
  end

  // Input register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_in;
      s1_last_r <= in_end_of_text;
    end
  end

  // Decoder state advances once per byte moved into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      need_r <= '0;
      held_r <= '0;
      run_r  <= '0;
    end else if (s1_adv) begin
      part_r <= part_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
      run_r  <= run_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_cp_done_r       <= out_cp_done_nxt;
      out_codepoint_r     <= out_codepoint_nxt;
      out_char_width_r    <= out_char_width_nxt;
      out_invalid_bytes_r <= out_invalid_bytes_nxt;
      out_total_width_r   <= out_total_width_nxt;
      out_text_done_r     <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cp_done       = out_cp_done_r;
  assign out_codepoint     = out_codepoint_r;
  assign out_char_width    = out_char_width_r;
  assign out_invalid_bytes = out_invalid_bytes_r;
  assign out_total_width   = out_total_width_r;
  assign out_text_done     = out_text_done_r;

endmodule

### hw/rtl/udws_checker.sv
// Port-level checker for the display width scanner and its bind to the top level.
`include "utf8_display_width_scanner_defines.svh"

module udws_checker
  import udws_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_cp_done,
  input logic [CP_W-1:0]    out_codepoint,
  input logic [CW_W-1:0]    out_char_width,
  input logic [INV_W-1:0]   out_invalid_bytes,
  input logic [TOTAL_W-1:0] out_total_width,
  input logic               out_text_done
);

  // A result without a completed codepoint carries no codepoint and no width.
  `UDWS_ASSERT_NOW(a_no_cp_no_width, out_valid && !out_cp_done, out_codepoint == '0 && out_char_width == '0)

  // A completed codepoint has zero width exactly when it is NUL, and never three.
  `UDWS_ASSERT_NOW(a_width_matches_cp, out_valid && out_cp_done, out_char_width != 2'd3 && ((out_codepoint == '0) == (out_char_width == '0)))

  // At most four bytes are discarded by one byte.
  `UDWS_ASSERT_NOW(a_inv_bounded, out_valid, out_invalid_bytes <= 3'd4)

  // A stalled result stays valid and keeps its payload.
  `UDWS_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_cp_done) && $stable(out_codepoint) && $stable(out_char_width) && $stable(out_invalid_bytes) && $stable(out_total_width) && $stable(out_text_done))

endmodule

bind utf8_display_width_scanner udws_checker u_udws_checker (.*);

### tb/tb.sv
// Self-checking testbench for the UTF-8 display width scanner.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import udws_pkg::*;

  // One scanner result as it appears on the output ports.
  typedef struct packed {
    logic               cp_done;
    logic [CP_W-1:0]    codepoint;
    logic [CW_W-1:0]    char_width;
    logic [INV_W-1:0]   invalid_bytes;
    logic [TOTAL_W-1:0] total_width;
    logic               text_done;
  } scan_result_t;

  // One row of the directed table; the result is typed in only when is_typed is set.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              eot;
    logic              is_typed;
    scan_result_t      want;
  } stim_row_t;

  localparam int WIDTH_MAX   = 65535;
  localparam int N_WIDE      = 18;
  localparam int N_DIRECTED  = 23;
  localparam int RANDOM_BYTES = 2000;

  // Codepoint ranges that take two terminal columns.
  localparam logic [CP_W-1:0] WIDE_LO [N_WIDE] = '{
    21'h01100, 21'h02329, 21'h02E80, 21'h03040, 21'h03400, 21'h04E00,
    21'h0A960, 21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF00,
    21'h0FFE0, 21'h1B000, 21'h1F004, 21'h1F300, 21'h20000, 21'h30000};
  localparam logic [CP_W-1:0] WIDE_HI [N_WIDE] = '{
    21'h0115F, 21'h0232A, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h0A4CF,
    21'h0A97F, 21'h0D7FF, 21'h0FAFF, 21'h0FE1F, 21'h0FE6F, 21'h0FF60,
    21'h0FFE6, 21'h1B0FF, 21'h1F0CF, 21'h1F9FF, 21'h2FFFD, 21'h3FFFD};

  // Directed bytes: byte classes, each sequence length, abort, unfinished end, overlong.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h00, 1'b0, 1'b1, '{1'b1, 21'h0,  2'd0, 3'd0, 16'd0, 1'b0}},
    '{8'h7F, 1'b0, 1'b1, '{1'b1, 21'h7F, 2'd1, 3'd0, 16'd1, 1'b0}},
    '{8'h80, 1'b0, 1'b1, '{1'b0, 21'h0,  2'd0, 3'd1, 16'd1, 1'b0}},
    '{8'hC1, 1'b0, 1'b1, '{1'b0, 21'h0,  2'd0, 3'd1, 16'd1, 1'b0}},
    '{8'hFF, 1'b1, 1'b1, '{1'b0, 21'h0,  2'd0, 3'd1, 16'd1, 1'b1}},
    '{8'hC2, 1'b0, 1'b1, '{1'b0, 21'h0,  2'd0, 3'd0, 16'd0, 1'b0}},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'h9F, 1'b0, 1'b0, '0},
    '{8'h8C, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'hF7, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hBF, 1'b0, 1'b0, '0},
    '{8'hE4, 1'b0, 1'b0, '0},
    '{8'hB8, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'h90, 1'b1, 1'b0, '0},
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0}};

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  in_data_in = '0;
  logic               in_end_of_text = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_cp_done;
  logic [CP_W-1:0]    out_codepoint;
  logic [CW_W-1:0]    out_char_width;
  logic [INV_W-1:0]   out_invalid_bytes;
  logic [TOTAL_W-1:0] out_total_width;
  logic               out_text_done;

  // Decoder state mirrored by the predictor.
  logic [CP_W-1:0] pend_code;
  int              pend_need;
  int              pend_held;
  int              line_width;

  scan_result_t awaited_scans[$];
  int           error_count = 0;
  int           bytes_sent = 0;
  int           stall_left = 0;
  bit           calm = 1'b0;

  utf8_display_width_scanner uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_data_in        (in_data_in),
    .in_end_of_text    (in_end_of_text),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cp_done       (out_cp_done),
    .out_codepoint     (out_codepoint),
    .out_char_width    (out_char_width),
    .out_invalid_bytes (out_invalid_bytes),
    .out_total_width   (out_total_width),
    .out_text_done     (out_text_done)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Terminal columns of a codepoint.
  function automatic int columns_of(input logic [CP_W-1:0] cp);
    int i;
    if (cp == '0) begin
      return 0;
    end
    for (i = 0; i < N_WIDE; i++) begin
      if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i]) begin
        return 2;
      end
    end
    return 1;
  endfunction

  // Advance the mirrored decoder by one byte and return the result it must produce.
  function automatic scan_result_t decode_and_measure(input logic [BYTE_W-1:0] b,
                                                      input logic eot);
    scan_result_t r;
    logic         taken;
    logic         done;
    int           discarded;
    int           cols;
    logic [CP_W-1:0] cp;
    r = '0;
    taken = 1'b0;
    done = 1'b0;
    discarded = 0;
    cols = 0;
    cp = '0;
    // A pending sequence either takes a continuation byte or is aborted.
    if (pend_need != 0) begin
      if ((b & CONT_MASK) == CONT_TAG) begin
        pend_code = {pend_code[CP_W-7:0], b[5:0]};
        pend_need--;
        taken = 1'b1;
        if (pend_need == 0) begin
          done = 1'b1;
          cp = pend_code;
          pend_held = 0;
          pend_code = '0;
        end else begin
          pend_held++;
        end
      end else begin
        discarded += pend_held;
        pend_need = 0;
        pend_held = 0;
        pend_code = '0;
      end
    end
    // Otherwise the byte is classified as a lead byte.
    if (!taken) begin
      if (b < ASCII_LIMIT) begin
        done = 1'b1;
        cp = {13'd0, b};
      end else if (b < LEAD2_MIN) begin
        discarded++;
      end else if (b < LEAD3_MIN) begin
        pend_code = {13'd0, b & LEAD2_BITS};
        pend_need = 1;
        pend_held = 1;
      end else if (b < LEAD4_MIN) begin
        pend_code = {13'd0, b & LEAD3_BITS};
        pend_need = 2;
        pend_held = 1;
      end else if (b < LEAD_BAD_MIN) begin
        pend_code = {13'd0, b & LEAD4_BITS};
        pend_need = 3;
        pend_held = 1;
      end else begin
        discarded++;
      end
    end
    // A sequence left open by the final byte is discarded.
    if (eot && pend_need != 0) begin
      discarded += pend_held;
      pend_need = 0;
      pend_held = 0;
      pend_code = '0;
    end
    if (done) begin
      cols = columns_of(cp);
      line_width = (line_width + cols > WIDTH_MAX) ? WIDTH_MAX : line_width + cols;
    end
    r.cp_done = done;
    r.codepoint = done ? cp : '0;
    r.char_width = CW_W'(cols);
    r.invalid_bytes = INV_W'(discarded);
    r.total_width = TOTAL_W'(line_width);
    r.text_done = eot;
    if (eot) begin
      line_width = 0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Offer one byte and record the expected result once the transfer happens.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot,
                           input logic is_typed, input scan_result_t lit);
    int           gap;
    scan_result_t predicted;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data_in <= b;
    in_end_of_text <= eot;
    do begin
      @(posedge clk);
    end while (in_stall);
    predicted = decode_and_measure(b, eot);
    awaited_scans.push_back(is_typed ? lit : predicted);
    bytes_sent++;
  endtask

  function automatic logic random_eot();
    return ($urandom_range(0, 39) == 0);
  endfunction

  // Encode a codepoint in the given number of bytes and send it.
  task automatic send_code(input logic [CP_W-1:0] cp, input int nb);
    logic [BYTE_W-1:0] seq [4];
    int                i;
    case (nb)
      1: begin
        seq[0] = {1'b0, cp[6:0]};
      end
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (i = 0; i < nb; i++) begin
      send_byte(seq[i], random_eot(), 1'b0, '0);
    end
  endtask

  function automatic int length_for(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      return 1;
    end else if (cp < 21'h800) begin
      return 2;
    end else if (cp < 21'h10000) begin
      return 3;
    end
    return 4;
  endfunction

  // One random item: mostly well-formed characters, some broken sequences and noise.
  task automatic send_random_item();
    int              r;
    int              k;
    int              nb;
    int              i;
    logic [CP_W-1:0] cp;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      send_code(CP_W'($urandom_range(0, 8'h7F)), 1);
    end else if (r < 32) begin
      send_code(CP_W'($urandom_range(12'h080, 12'h7FF)), 2);
    end else if (r < 44) begin
      send_code(CP_W'($urandom_range(0, 16'hFFFF)), 3);
    end else if (r < 54) begin
      send_code(CP_W'($urandom_range(0, 21'h1FFFFF)), 4);
    end else if (r < 72) begin
      // Near or inside a double-width range, edges included.
      k = $urandom_range(0, N_WIDE - 1);
      case ($urandom_range(0, 4))
        0: cp = WIDE_LO[k] - 1'b1;
        1: cp = WIDE_LO[k];
        2: cp = WIDE_HI[k];
        3: cp = WIDE_HI[k] + 1'b1;
        default: cp = CP_W'($urandom_range(WIDE_LO[k], WIDE_HI[k]));
      endcase
      send_code(cp, length_for(cp));
    end else if (r < 86) begin
      // Lead byte followed by too few continuation bytes.
      nb = $urandom_range(2, 4);
      case (nb)
        2: send_byte(BYTE_W'($urandom_range(8'hC2, 8'hDF)), random_eot(), 1'b0, '0);
        3: send_byte(BYTE_W'($urandom_range(8'hE0, 8'hEF)), random_eot(), 1'b0, '0);
        default: send_byte(BYTE_W'($urandom_range(8'hF0, 8'hF7)), random_eot(), 1'b0, '0);
      endcase
      k = $urandom_range(0, nb - 2);
      for (i = 0; i < k; i++) begin
        send_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)), random_eot(), 1'b0, '0);
      end
    end else begin
      send_byte(BYTE_W'($urandom_range(0, 255)), random_eot(), 1'b0, '0);
    end
  endtask

  // Hold the sender off until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_scans.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Output stall: random bursts, mostly short, paused while calm.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (!calm && $urandom_range(0, 9) < 3) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) :
                                                   $urandom_range(1, 3);
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    scan_result_t got;
    scan_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_cp_done, out_codepoint, out_char_width, out_invalid_bytes,
             out_total_width, out_text_done};
      if (awaited_scans.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
        want = awaited_scans.pop_front();
        if (got.cp_done !== want.cp_done) begin
          report_mismatch($sformatf("cp_done got %b want %b", got.cp_done, want.cp_done));
        end
        if (got.codepoint !== want.codepoint) begin
          report_mismatch($sformatf("codepoint got %h want %h",
                                    got.codepoint, want.codepoint));
        end
        if (got.char_width !== want.char_width) begin
          report_mismatch($sformatf("char_width got %0d want %0d",
                                    got.char_width, want.char_width));
        end
        if (got.invalid_bytes !== want.invalid_bytes) begin
          report_mismatch($sformatf("invalid_bytes got %0d want %0d",
                                    got.invalid_bytes, want.invalid_bytes));
        end
        if (got.total_width !== want.total_width) begin
          report_mismatch($sformatf("total_width got %0d want %0d",
                                    got.total_width, want.total_width));
        end
        if (got.text_done !== want.text_done) begin
          report_mismatch($sformatf("text_done got %b want %b",
                                    got.text_done, want.text_done));
        end
      end
    end
  end

  // Main sequence: reset, directed table, random text, wind-down.
  initial begin
    int i;
    int start;
    pend_code = '0;
    pend_need = 0;
    pend_held = 0;
    line_width = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < N_DIRECTED; i++) begin
      send_byte(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].eot,
                DIRECTED_ROWS[i].is_typed, DIRECTED_ROWS[i].want);
    end
    drain_results();

    // Random text, switching between idle-heavy and back-to-back stretches.
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      if ((bytes_sent - start) % 200 < 4) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      send_random_item();
    end
    drain_results();

    calm = 1'b0;
    for (i = 0; i < 40; i++) begin
      send_random_item();
    end
    drain_results();
    repeat (10) @(posedge clk);

    if (awaited_scans.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", awaited_scans.size()));
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/udws_pkg.sv
hw/rtl/utf8_display_width_scanner.sv
hw/rtl/udws_checker.sv
tb/tb.sv
